// ----- rtl/core/ale_frame_receiver_assert.svh -----
// Assertion macros for the ALE frame receiver.
`ifndef ALE_FRAME_RECEIVER_ASSERT_SVH
`define ALE_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define AFR_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define AFR_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AFR_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define AFR_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/afr_pkg.sv -----
// Shared constants, CRC function and packet class function for the ALE frame receiver.
`default_nettype none

package afr_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_MSB  = 16'h8000;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // header byte positions, counted from the length high byte
    localparam logic [3:0] POS_FIRST_HDR = 4'd2;
    localparam logic [3:0] POS_APP_TYPE  = 4'd3;
    localparam logic [3:0] POS_PKT_TYPE  = 4'd7;
    localparam logic [3:0] POS_CHK_HI    = 4'd8;
    localparam logic [3:0] POS_CHK_LO    = 4'd9;
    localparam logic [3:0] CRC_BYTES     = 4'd8;
    localparam logic [3:0] ID_LAST_POS   = 4'd3;

    localparam logic [15:0] MIN_FRAME_LEN = 16'd8;
    localparam logic [15:0] ID_LEN        = 16'd4;

    localparam logic [7:0] APP_TYPE_KIND_ONE   = 8'd16;
    localparam logic [7:0] APP_TYPE_KIND_OTHER = 8'd17;
    localparam logic [7:0] RESP_TYPE_ONE       = 8'd1;

    localparam logic [7:0] PKT_CONNECT_CONF = 8'd2;
    localparam logic [7:0] PKT_DATA         = 8'd3;
    localparam logic [7:0] PKT_DISCONNECT   = 8'd4;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_PEER_ID = 2'd1;
    localparam logic [1:0] KIND_EMPTY   = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [1:0] CLS_CONNECT    = 2'd0;
    localparam logic [1:0] CLS_DATA       = 2'd1;
    localparam logic [1:0] CLS_DISCONNECT = 2'd2;

    localparam logic [1:0] ERR_CHECKSUM  = 2'd0;
    localparam logic [1:0] ERR_APP_TYPE  = 2'd1;
    localparam logic [1:0] ERR_TOO_SHORT = 2'd2;

    // one byte of CRC-16, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_MSB) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [1:0] class_of(input logic [7:0] ptype);
        logic [1:0] cls;
        cls = CLS_CONNECT;
        if (ptype == PKT_DATA) begin
            cls = CLS_DATA;
        end else if (ptype == PKT_DISCONNECT) begin
            cls = CLS_DISCONNECT;
        end
        return cls;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ale_frame_receiver.sv -----
// ALE frame receiver: deframes a byte stream, checks header CRC and type.
//
// Input channel s_valid/s_ready carries one received stream byte per item
// (s_rx_byte). Result channel m_valid/m_ready carries at most one result per
// input byte: payload byte, peer identified, empty message or error.
// cfg_wr_en/cfg_wr_data set the peer kind register; a write also forgets a
// peer kind learned from a connect confirm frame. Write it only while idle.
// A byte accepted into the input register is processed while it sits there,
// and its result is captured in the result register as the byte advances.
// Throughput is one byte per cycle while no result waits on a low m_ready;
// the CRC byte update and frame state step sit between the input register
// and the result register.
// When m_ready is low and a result is waiting, the input register holds one
// byte and s_ready drops until the result is taken.
// Reset (aresetn low, synchronous) empties both registers, returns to the
// start of a frame and clears the halt. After an error result every further
// byte is consumed with no result until reset.
`default_nettype none

`include "ale_frame_receiver_assert.svh"

module ale_frame_receiver (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_result_kind,
    output logic [1:0]       m_message_class,
    output logic [7:0]       m_data_byte,
    output logic             m_last_of_message,
    output logic [7:0]       m_responder_type,
    output logic [23:0]      m_peer_ident,
    output logic [1:0]       m_error_code
);

    typedef enum logic [2:0] {
        PH_LEN_HI,
        PH_LEN_LO,
        PH_HEADER,
        PH_IDENT,
        PH_PAYLOAD,
        PH_DISCARD
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [3:0]  hdr_pos_reg, hdr_pos_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] chk_reg, chk_next;
    logic [7:0]  app_type_reg, app_type_next;
    logic [7:0]  pkt_type_reg, pkt_type_next;
    logic [31:0] resp_shift_reg, resp_shift_next;
    logic [1:0]  learned_reg, learned_next;   // bit1 learned, bit0 kind is one
    logic        halted_reg, halted_next;
    logic        peer_one_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        advance;

    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic [1:0]  out_cls_reg;
    logic [7:0]  out_data_reg;
    logic        out_last_reg;
    logic [7:0]  out_rtype_reg;
    logic [23:0] out_rid_reg;
    logic [1:0]  out_err_reg;

    logic        emit;
    logic [1:0]  e_kind;
    logic [1:0]  e_cls;
    logic [7:0]  e_data;
    logic        e_last;
    logic [7:0]  e_rtype;
    logic [23:0] e_rid;
    logic [1:0]  e_err;

    logic [15:0] bl_dec;
    logic [15:0] crc_upd;
    logic [15:0] len_full;
    logic [15:0] chk_full;
    logic        kind_one;
    logic [7:0]  app_expect;
    logic        err_shown;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign bl_dec     = bytes_left_reg - 16'd1;
    assign crc_upd    = afr_pkg::crc16_byte(crc_reg, in_byte_reg);
    assign len_full   = {bytes_left_reg[15:8], in_byte_reg};
    assign chk_full   = {chk_reg[15:8], in_byte_reg};
    assign kind_one   = learned_reg[1] ? learned_reg[0] : peer_one_reg;
    assign app_expect = kind_one ? afr_pkg::APP_TYPE_KIND_ONE : afr_pkg::APP_TYPE_KIND_OTHER;

    always_comb begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        hdr_pos_next    = hdr_pos_reg;
        crc_next        = crc_reg;
        chk_next        = chk_reg;
        app_type_next   = app_type_reg;
        pkt_type_next   = pkt_type_reg;
        resp_shift_next = resp_shift_reg;
        learned_next    = learned_reg;
        halted_next     = halted_reg;
        emit    = 1'b0;
        e_kind  = afr_pkg::KIND_PAYLOAD;
        e_cls   = afr_pkg::CLS_CONNECT;
        e_data  = 8'h00;
        e_last  = 1'b0;
        e_rtype = 8'h00;
        e_rid   = 24'h000000;
        e_err   = afr_pkg::ERR_CHECKSUM;

        if (advance && !halted_reg) begin
            case (phase_reg)
                PH_LEN_HI: begin
                    crc_next        = afr_pkg::crc16_byte(afr_pkg::CRC_INIT, in_byte_reg);
                    bytes_left_next = {in_byte_reg, 8'h00};
                    phase_next      = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    crc_next        = crc_upd;
                    bytes_left_next = len_full;
                    if (len_full < afr_pkg::MIN_FRAME_LEN) begin
                        halted_next = 1'b1;
                        emit        = 1'b1;
                        e_kind      = afr_pkg::KIND_ERROR;
                        e_last      = 1'b1;
                        e_err       = afr_pkg::ERR_TOO_SHORT;
                    end else begin
                        hdr_pos_next = afr_pkg::POS_FIRST_HDR;
                        phase_next   = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    bytes_left_next = bl_dec;
                    if (hdr_pos_reg < afr_pkg::CRC_BYTES) begin
                        crc_next = crc_upd;
                    end
                    if (hdr_pos_reg == afr_pkg::POS_APP_TYPE) begin
                        app_type_next = in_byte_reg;
                    end else if (hdr_pos_reg == afr_pkg::POS_PKT_TYPE) begin
                        pkt_type_next = in_byte_reg;
                    end else if (hdr_pos_reg == afr_pkg::POS_CHK_HI) begin
                        chk_next = {in_byte_reg, 8'h00};
                    end else if (hdr_pos_reg == afr_pkg::POS_CHK_LO) begin
                        chk_next = chk_full;
                    end
                    if (hdr_pos_reg < afr_pkg::POS_CHK_LO) begin
                        hdr_pos_next = hdr_pos_reg + 4'd1;
                    end else begin
                        hdr_pos_next = 4'd0;
                        // check order: checksum, app type, then packet type and its length
                        if (chk_full != crc_reg) begin
                            halted_next = 1'b1;
                            emit        = 1'b1;
                            e_kind      = afr_pkg::KIND_ERROR;
                            e_last      = 1'b1;
                            e_err       = afr_pkg::ERR_CHECKSUM;
                        end else if (app_type_reg != app_expect) begin
                            halted_next = 1'b1;
                            emit        = 1'b1;
                            e_kind      = afr_pkg::KIND_ERROR;
                            e_last      = 1'b1;
                            e_err       = afr_pkg::ERR_APP_TYPE;
                        end else if (pkt_type_reg == afr_pkg::PKT_CONNECT_CONF) begin
                            if (bl_dec < afr_pkg::ID_LEN) begin
                                halted_next = 1'b1;
                                emit        = 1'b1;
                                e_kind      = afr_pkg::KIND_ERROR;
                                e_last      = 1'b1;
                                e_err       = afr_pkg::ERR_TOO_SHORT;
                            end else begin
                                resp_shift_next = 32'h0;
                                phase_next      = PH_IDENT;
                            end
                        end else if (pkt_type_reg == afr_pkg::PKT_DATA ||
                                     pkt_type_reg == afr_pkg::PKT_DISCONNECT) begin
                            if (bl_dec == 16'd0) begin
                                phase_next = PH_LEN_HI;
                                emit       = 1'b1;
                                e_kind     = afr_pkg::KIND_EMPTY;
                                e_cls      = afr_pkg::class_of(pkt_type_reg);
                                e_last     = 1'b1;
                            end else begin
                                phase_next = PH_PAYLOAD;
                            end
                        end else begin
                            // unknown packet type: drop the rest of the frame
                            phase_next = (bl_dec == 16'd0) ? PH_LEN_HI : PH_DISCARD;
                        end
                    end
                end
                PH_IDENT: begin
                    bytes_left_next = bl_dec;
                    resp_shift_next = {resp_shift_reg[23:0], in_byte_reg};
                    if (hdr_pos_reg != afr_pkg::ID_LAST_POS) begin
                        hdr_pos_next = hdr_pos_reg + 4'd1;
                    end else begin
                        hdr_pos_next = 4'd0;
                        learned_next = {1'b1, resp_shift_reg[23:16] == afr_pkg::RESP_TYPE_ONE};
                        phase_next   = (bl_dec == 16'd0) ? PH_LEN_HI : PH_PAYLOAD;
                        emit         = 1'b1;
                        e_kind       = afr_pkg::KIND_PEER_ID;
                        e_last       = (bl_dec == 16'd0);
                        e_rtype      = resp_shift_reg[23:16];
                        e_rid        = {resp_shift_reg[15:0], in_byte_reg};
                    end
                end
                PH_PAYLOAD: begin
                    bytes_left_next = bl_dec;
                    if (bl_dec == 16'd0) begin
                        phase_next = PH_LEN_HI;
                    end
                    emit   = 1'b1;
                    e_kind = afr_pkg::KIND_PAYLOAD;
                    e_cls  = afr_pkg::class_of(pkt_type_reg);
                    e_data = in_byte_reg;
                    e_last = (bl_dec == 16'd0);
                end
                PH_DISCARD: begin
                    bytes_left_next = bl_dec;
                    if (bl_dec == 16'd0) begin
                        phase_next = PH_LEN_HI;
                    end
                end
                default: begin
                    phase_next = PH_LEN_HI;
                end
            endcase
        end

        // a register write forgets the learned peer kind
        if (cfg_wr_en) begin
            learned_next = 2'b00;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_LEN_HI;
            bytes_left_reg <= 16'h0000;
            hdr_pos_reg    <= 4'd0;
            crc_reg        <= afr_pkg::CRC_INIT;
            chk_reg        <= 16'h0000;
            app_type_reg   <= 8'h00;
            pkt_type_reg   <= 8'h00;
            resp_shift_reg <= 32'h0;
            learned_reg    <= 2'b00;
            halted_reg     <= 1'b0;
            peer_one_reg   <= 1'b0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= afr_pkg::KIND_PAYLOAD;
            out_cls_reg    <= afr_pkg::CLS_CONNECT;
            out_data_reg   <= 8'h00;
            out_last_reg   <= 1'b0;
            out_rtype_reg  <= 8'h00;
            out_rid_reg    <= 24'h000000;
            out_err_reg    <= afr_pkg::ERR_CHECKSUM;
        end else begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            hdr_pos_reg    <= hdr_pos_next;
            crc_reg        <= crc_next;
            chk_reg        <= chk_next;
            app_type_reg   <= app_type_next;
            pkt_type_reg   <= pkt_type_next;
            resp_shift_reg <= resp_shift_next;
            learned_reg    <= learned_next;
            halted_reg     <= halted_next;
            if (cfg_wr_en) begin
                peer_one_reg <= cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
                out_kind_reg  <= e_kind;
                out_cls_reg   <= e_cls;
                out_data_reg  <= e_data;
                out_last_reg  <= e_last;
                out_rtype_reg <= e_rtype;
                out_rid_reg   <= e_rid;
                out_err_reg   <= e_err;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // input payload register
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_result_kind     = out_kind_reg;
    assign m_message_class   = out_cls_reg;
    assign m_data_byte       = out_data_reg;
    assign m_last_of_message = out_last_reg;
    assign m_responder_type  = out_rtype_reg;
    assign m_peer_ident      = out_rid_reg;
    assign m_error_code      = out_err_reg;

    assign err_shown = m_valid && (m_result_kind == afr_pkg::KIND_ERROR);

    // once halted, only reset leaves the halt
    `AFR_ASSERT_NXT(a_halt_sticky, aclk, aresetn, halted_reg, halted_reg)
    // an error result always closes its frame
    `AFR_ASSERT_IMP(a_err_last, aclk, aresetn, err_shown, m_last_of_message)
    // a result is produced only from a byte sitting in the input register
    `AFR_ASSERT_IMP(a_emit_src, aclk, aresetn, emit, advance && !halted_reg)

endmodule

`default_nettype wire
